// ===== hw/rtl/crmfe_pkg.sv =====
package crmfe_pkg;

   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int PIX_W       = 32;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;

   localparam logic [1:0] ROT_90    = 2'd1;
   localparam logic [1:0] ROT_180   = 2'd2;
   localparam logic [1:0] ROT_270   = 2'd3;
   localparam logic [1:0] MIR_VFLIP = 2'd1;
   localparam logic [1:0] MIR_HFLIP = 2'd2;

   typedef struct packed {
      logic [8:0] src_width;
      logic [8:0] src_height;
      logic [7:0] crop_x;
      logic [7:0] crop_y;
      logic [8:0] crop_w;
      logic [8:0] crop_h;
      logic [1:0] rotate_quarters;
      logic [1:0] mirror_mode;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      src_width:       9'd256,
      src_height:      9'd256,
      crop_x:          8'd0,
      crop_y:          8'd0,
      crop_w:          9'd256,
      crop_h:          9'd256,
      rotate_quarters: 2'd0,
      mirror_mode:     2'd0
   };

   typedef enum logic [2:0] {
      REG_SRC_WIDTH  = 3'd0,
      REG_SRC_HEIGHT = 3'd1,
      REG_CROP_X     = 3'd2,
      REG_CROP_Y     = 3'd3,
      REG_CROP_W     = 3'd4,
      REG_CROP_H     = 3'd5,
      REG_ROTATE     = 3'd6,
      REG_MIRROR     = 3'd7
   } reg_index_type;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_FETCH = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      RES_LOADED    = 2'd0,
      RES_DELIVERED = 2'd1,
      RES_ERROR     = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_MAP,
      ST_ADDR,
      ST_READ,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

endpackage

// ===== hw/rtl/crmfe_csr.sv =====
module crmfe_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [crmfe_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [crmfe_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [crmfe_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready,
   output crmfe_pkg::cfg_type                  cfg
);
   import crmfe_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign index      = reg_index_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_SRC_WIDTH:  cfg_in.src_width       = csr_pwdata[8:0];
            REG_SRC_HEIGHT: cfg_in.src_height      = csr_pwdata[8:0];
            REG_CROP_X:     cfg_in.crop_x          = csr_pwdata[7:0];
            REG_CROP_Y:     cfg_in.crop_y          = csr_pwdata[7:0];
            REG_CROP_W:     cfg_in.crop_w          = csr_pwdata[8:0];
            REG_CROP_H:     cfg_in.crop_h          = csr_pwdata[8:0];
            REG_ROTATE:     cfg_in.rotate_quarters = csr_pwdata[1:0];
            REG_MIRROR:     cfg_in.mirror_mode     = csr_pwdata[1:0];
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_SRC_WIDTH:  csr_prdata = CSR_DATA_W'(cfg_ff.src_width);
         REG_SRC_HEIGHT: csr_prdata = CSR_DATA_W'(cfg_ff.src_height);
         REG_CROP_X:     csr_prdata = CSR_DATA_W'(cfg_ff.crop_x);
         REG_CROP_Y:     csr_prdata = CSR_DATA_W'(cfg_ff.crop_y);
         REG_CROP_W:     csr_prdata = CSR_DATA_W'(cfg_ff.crop_w);
         REG_CROP_H:     csr_prdata = CSR_DATA_W'(cfg_ff.crop_h);
         REG_ROTATE:     csr_prdata = CSR_DATA_W'(cfg_ff.rotate_quarters);
         REG_MIRROR:     csr_prdata = CSR_DATA_W'(cfg_ff.mirror_mode);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hw/rtl/crmfe_ctrl.sv =====
module crmfe_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic               rsp_tready,
   output logic               rsp_tvalid,
   output crmfe_pkg::cmd_type cmd
);
   import crmfe_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CALC;
            end
         end
         ST_CALC: state_in = ST_MAP;
         ST_MAP:  state_in = ST_ADDR;
         ST_ADDR: state_in = ST_READ;
         ST_READ: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_capture_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == ST_CALC)
      else $error("capture did not start the sequence");

   a_commit_presents: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed request not presented");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !cmd.commit)
      else $error("pending request result overwritten");

   a_commit_in_done: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> state_ff == ST_DONE)
      else $error("commit outside done state");

endmodule

// ===== hw/rtl/crmfe_dpath.sv =====
module crmfe_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  crmfe_pkg::cfg_type              cfg,
   input  crmfe_pkg::cmd_type              cmd,
   input  logic [0:0]                      req_tuser,
   input  logic [crmfe_pkg::PIX_W-1:0]     req_tdata,
   output logic [crmfe_pkg::PIX_W-1:0]     rsp_tdata,
   output logic                            rsp_tlast,
   output logic [1:0]                      rsp_tuser
);
   import crmfe_pkg::*;

   // request capture
   op_type                op_ff;
   logic [PIX_W-1:0]      pix_ff;

   // frame counters
   logic [CNT_W-1:0]      load_count_ff, load_count_in;
   logic [7:0]            out_col_ff, out_col_in;
   logic [7:0]            out_row_ff, out_row_in;

   // check and mirror stage
   logic                  size_ok_ff, size_ok_in;
   logic [17:0]           total_ff, total_in;
   logic                  crop_ok_ff, crop_ok_in;
   logic                  range_ok_ff, range_ok_in;
   logic                  last_ff, last_in;
   logic                  wrap_ff, wrap_in;
   logic [7:0]            mc_ff, mc_in;
   logic [7:0]            mr_ff, mr_in;
   logic [8:0]            ow, oh, mc9, mr9;

   // rotation stage
   logic [7:0]            src_col_ff, src_col_in;
   logic [7:0]            src_row_ff, src_row_in;
   logic [8:0]            x9, y9, col_sum, row_sum;

   // address stage
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic [CNT_W-1:0]      addr_sum;

   logic [PIX_W-1:0]      frame_mem [STORE_DEPTH];
   logic [PIX_W-1:0]      rd_data_ff;

   logic [PIX_W-1:0]      rsp_pixel_ff;
   logic                  rsp_last_ff;
   status_type            rsp_status_ff;

   logic                  full;
   status_type            res_status;
   logic                  do_write, do_deliver, do_clear;

   always_comb begin
      size_ok_in = (cfg.src_width != '0) && (cfg.src_width <= 9'(MAX_WIDTH)) &&
                   (cfg.src_height != '0) && (cfg.src_height <= 9'(MAX_HEIGHT));
      total_in   = 18'(cfg.src_width) * 18'(cfg.src_height);
      crop_ok_in = (cfg.crop_w != '0) && (cfg.crop_h != '0) &&
                   ((10'(cfg.crop_x) + 10'(cfg.crop_w)) <= 10'(cfg.src_width)) &&
                   ((10'(cfg.crop_y) + 10'(cfg.crop_h)) <= 10'(cfg.src_height));
      ow = cfg.rotate_quarters[0] ? cfg.crop_h : cfg.crop_w;
      oh = cfg.rotate_quarters[0] ? cfg.crop_w : cfg.crop_h;
      range_ok_in = (9'(out_col_ff) < ow) && (9'(out_row_ff) < oh);
      last_in     = (9'(out_col_ff) == (ow - 9'd1)) && (9'(out_row_ff) == (oh - 9'd1));
      wrap_in     = (9'(out_col_ff) + 9'd1) >= ow;
      mc9 = 9'(out_col_ff);
      mr9 = 9'(out_row_ff);
      unique case (cfg.mirror_mode)
         MIR_VFLIP: mr9 = oh - 9'd1 - 9'(out_row_ff);
         MIR_HFLIP: mc9 = ow - 9'd1 - 9'(out_col_ff);
         default:   ;
      endcase
      mc_in = mc9[7:0];
      mr_in = mr9[7:0];
   end

   always_comb begin
      unique case (cfg.rotate_quarters)
         ROT_90: begin
            x9 = cfg.crop_w - 9'd1 - 9'(mr_ff);
            y9 = 9'(mc_ff);
         end
         ROT_180: begin
            x9 = cfg.crop_w - 9'd1 - 9'(mc_ff);
            y9 = cfg.crop_h - 9'd1 - 9'(mr_ff);
         end
         ROT_270: begin
            x9 = 9'(mr_ff);
            y9 = cfg.crop_h - 9'd1 - 9'(mc_ff);
         end
         default: begin
            x9 = 9'(mc_ff);
            y9 = 9'(mr_ff);
         end
      endcase
      col_sum    = 9'(cfg.crop_x) + x9;
      row_sum    = 9'(cfg.crop_y) + y9;
      src_col_in = col_sum[7:0];
      src_row_in = row_sum[7:0];
   end

   assign addr_sum = (CNT_W'(src_row_ff) * CNT_W'(cfg.src_width)) + CNT_W'(src_col_ff);
   assign addr_in  = addr_sum[ADDR_W-1:0];

   assign full = 18'(load_count_ff) >= total_ff;

   always_comb begin
      res_status = RES_ERROR;
      do_write   = 1'b0;
      do_deliver = 1'b0;
      do_clear   = 1'b0;
      priority if (!size_ok_ff) begin
         res_status = RES_ERROR;
      end else if (op_ff == OP_LOAD) begin
         if (!full) begin
            res_status = RES_LOADED;
            do_write   = 1'b1;
         end
      end else if (!full || !crop_ok_ff) begin
         res_status = RES_ERROR;
      end else if (!range_ok_ff) begin
         do_clear = 1'b1;
      end else begin
         res_status = RES_DELIVERED;
         do_deliver = 1'b1;
      end
   end

   always_comb begin
      load_count_in = load_count_ff;
      out_col_in    = out_col_ff;
      out_row_in    = out_row_ff;
      if (cmd.commit) begin
         if (do_write) begin
            load_count_in = load_count_ff + CNT_W'(1);
         end
         if (do_clear) begin
            out_col_in = '0;
            out_row_in = '0;
         end
         if (do_deliver) begin
            priority if (last_ff) begin
               out_col_in    = '0;
               out_row_in    = '0;
               load_count_in = '0;
            end else if (wrap_ff) begin
               out_col_in = '0;
               out_row_in = out_row_ff + 8'd1;
            end else begin
               out_col_in = out_col_ff + 8'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
      end else begin
         load_count_ff <= load_count_in;
         out_col_ff    <= out_col_in;
         out_row_ff    <= out_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= op_type'(req_tuser[0]);
         pix_ff <= req_tdata;
      end
      size_ok_ff  <= size_ok_in;
      total_ff    <= total_in;
      crop_ok_ff  <= crop_ok_in;
      range_ok_ff <= range_ok_in;
      last_ff     <= last_in;
      wrap_ff     <= wrap_in;
      mc_ff       <= mc_in;
      mr_ff       <= mr_in;
      src_col_ff  <= src_col_in;
      src_row_ff  <= src_row_in;
      addr_ff     <= addr_in;
      if (cmd.commit) begin
         rsp_pixel_ff  <= do_deliver ? rd_data_ff : '0;
         rsp_last_ff   <= do_deliver && last_ff;
         rsp_status_ff <= res_status;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && do_write) begin
         frame_mem[load_count_ff[ADDR_W-1:0]] <= pix_ff;
      end
      rd_data_ff <= frame_mem[addr_ff];
   end

   assign rsp_tdata = rsp_pixel_ff;
   assign rsp_tlast = rsp_last_ff;
   assign rsp_tuser = rsp_status_ff;

endmodule

// ===== hw/rtl/crop_rotate_mirror_frame_engine.sv =====
// Frame engine: load a source frame of packed RGBA pixels (R in the low byte) in raster
// order with requests whose tuser is 0, then fetch it back with tuser 1, cropped, turned
// anticlockwise by quarter turns and mirrored, in raster order of the final image. Every
// request gives one response: tuser 0 loaded, 1 delivered (tdata the pixel, tlast on the
// final pixel, after which the counters clear), 2 error. Once a request is accepted the
// sequencer steps through its calc, map, address, read and done states; the response is
// registered as it leaves done, and only then does it return to idle to accept the next
// request. An untaken response waits in the output register and holds back the following
// request, keeping the sequencer in done until it is taken. These states cover the range
// checks, the mirror and rotate mapping, the address multiply and the registered read of
// the simple dual-port 64K x 32 frame memory (one write port, one read port).
// The frame memory holds no reset value and needs no clearing pass.
module crop_rotate_mirror_frame_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [crmfe_pkg::PIX_W-1:0]         req_tdata,   // pixel_in
   input  logic [0:0]                          req_tuser,   // operation
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [crmfe_pkg::PIX_W-1:0]         rsp_tdata,   // pixel_out
   output logic                                rsp_tlast,
   output logic [1:0]                          rsp_tuser,   // status
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [crmfe_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [crmfe_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [crmfe_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);
   import crmfe_pkg::*;

   cfg_type cfg;
   cmd_type cmd;

   crmfe_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   crmfe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd)
   );

   crmfe_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

endmodule
